### rtl/lhwf_pkg.sv
// Package for the left-hand wall follower: maze geometry, item kinds, headings,
// the step result handed from the walker to the record emitter, and cell helpers.
// Used by lhwf_walker, lhwf_emit and left_hand_wall_follower.
`default_nettype none

package lhwf_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_COLS  = 16;
    localparam int MAX_CELLS = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = $clog2(MAX_CELLS);

    // Rows and columns in use never exceed the store nor the 4-bit coordinates.
    localparam int ROW_LIM_I = (MAX_ROWS < 16) ? MAX_ROWS : 16;
    localparam int COL_LIM_I = (MAX_COLS < 16) ? MAX_COLS : 16;
    localparam logic [4:0] ROW_LIM = 5'(ROW_LIM_I);
    localparam logic [4:0] COL_LIM = 5'(COL_LIM_I);

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_RESTART = 2'd1;
    localparam logic [1:0] KIND_STEP    = 2'd2;

    localparam logic [1:0] DIR_N = 2'd0;
    localparam logic [1:0] DIR_E = 2'd1;
    localparam logic [1:0] DIR_S = 2'd2;
    localparam logic [1:0] DIR_W = 2'd3;

    localparam logic [2:0] CFG_MAZE_ROWS = 3'd0;
    localparam logic [2:0] CFG_MAZE_COLS = 3'd1;
    localparam logic [2:0] CFG_START_ROW = 3'd2;
    localparam logic [2:0] CFG_START_COL = 3'd3;
    localparam logic [2:0] CFG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] CFG_GOAL_COL  = 3'd5;

    typedef struct packed {
        logic [4:0] rows_used;
        logic [4:0] cols_used;
        logic [3:0] start_row;
        logic [3:0] start_col;
        logic [3:0] goal_row;
        logic [3:0] goal_col;
    } t_cfg;

    typedef struct packed {
        logic [3:0] old_row;
        logic [3:0] old_col;
        logic [1:0] old_head;
        logic       left_turn;
        logic [3:0] new_row;
        logic [3:0] new_col;
        logic [1:0] new_head;
        logic       goal;
    } t_step_res;

    typedef struct packed {
        logic       ok;
        logic [3:0] row;
        logic [3:0] col;
    } t_target;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [3:0] row,
                                                    input logic [3:0] col);
        return ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

    function automatic logic in_store(input logic [3:0] row, input logic [3:0] col);
        return (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
    endfunction

    // Neighbor cell in direction dir, and whether it lies inside the maze in use.
    function automatic t_target step_target(input logic [3:0] row,
                                            input logic [3:0] col,
                                            input logic [1:0] dir,
                                            input logic [4:0] rows,
                                            input logic [4:0] cols);
        t_target    t;
        logic [4:0] r5;
        logic [4:0] c5;
        r5   = {1'b0, row};
        c5   = {1'b0, col};
        t.ok = 1'b1;
        unique case (dir)
            DIR_N: begin
                if (row == 4'd0) t.ok = 1'b0;
                else r5 = r5 - 5'd1;
            end
            DIR_E: c5 = c5 + 5'd1;
            DIR_S: r5 = r5 + 5'd1;
            DIR_W: begin
                if (col == 4'd0) t.ok = 1'b0;
                else c5 = c5 - 5'd1;
            end
        endcase
        if (r5 >= rows || c5 >= cols) t.ok = 1'b0;
        t.row = r5[3:0];
        t.col = c5[3:0];
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/lhwf_walker.sv
// Walker core: holds the maze wall memory and the walker position, decodes items,
// and resolves each step with reads of the current, left and front cells.
// Depends on lhwf_pkg.
`default_nettype none

module lhwf_walker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lhwf_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [3:0]         i_cell_row,
    input  wire logic [3:0]         i_cell_col,
    input  wire logic [3:0]         i_wall_bits,
    output logic                    o_res_valid,
    input  wire logic               i_res_stall,
    output lhwf_pkg::t_step_res     o_res
);

    typedef enum logic [1:0] {
        W_IDLE,
        W_LEFT,
        W_FRONT
    } t_wstate;

    logic [3:0] r_mem [lhwf_pkg::MAX_CELLS];

    t_wstate    r_state, n_state;
    logic [3:0] r_row, n_row;
    logic [3:0] r_col, n_col;
    logic [1:0] r_head, n_head;
    logic       r_active, n_active;
    logic       r_done, n_done;
    logic [3:0] r_cur_w;
    logic [3:0] r_tgt_w;

    logic                in_acc;
    logic [1:0]          left_dir;
    logic [1:0]          left_opp;
    logic [1:0]          front_opp;
    lhwf_pkg::t_target   left_t;
    lhwf_pkg::t_target   front_t;
    lhwf_pkg::t_target   acc_left_t;
    logic [3:0]          cur_w;
    logic                left_ok;
    logic                front_ok;
    logic                fin;
    logic                step_done;
    logic                start_step;
    logic                rd_front;
    logic                wr_en;
    logic [3:0]          p_row;
    logic [3:0]          p_col;
    logic [1:0]          p_head;
    logic                p_done;

    assign left_dir  = r_head + 2'd3;
    assign left_opp  = left_dir + 2'd2;
    assign front_opp = r_head + 2'd2;

    assign left_t  = lhwf_pkg::step_target(r_row, r_col, left_dir,
                                           i_cfg.rows_used, i_cfg.cols_used);
    assign front_t = lhwf_pkg::step_target(r_row, r_col, r_head,
                                           i_cfg.rows_used, i_cfg.cols_used);

    // A walker outside the store sees walls all around.
    assign cur_w = lhwf_pkg::in_store(r_row, r_col) ? r_cur_w : 4'hF;

    assign left_ok  = left_t.ok && !cur_w[left_dir] && !r_tgt_w[left_opp];
    assign front_ok = front_t.ok && !cur_w[r_head] && !r_tgt_w[front_opp];

    assign fin       = (r_state == W_LEFT && left_ok) || (r_state == W_FRONT);
    assign step_done = fin && !i_res_stall;
    assign rd_front  = (r_state == W_LEFT) && !left_ok;

    assign o_stall = (r_state != W_IDLE) && !step_done;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        o_res.old_row   = r_row;
        o_res.old_col   = r_col;
        o_res.old_head  = r_head;
        o_res.left_turn = 1'b0;
        o_res.new_row   = r_row;
        o_res.new_col   = r_col;
        o_res.new_head  = r_head + 2'd1;
        if (r_state == W_LEFT) begin
            o_res.left_turn = 1'b1;
            o_res.new_row   = left_t.row;
            o_res.new_col   = left_t.col;
            o_res.new_head  = left_dir;
        end else if (front_ok) begin
            o_res.new_row  = front_t.row;
            o_res.new_col  = front_t.col;
            o_res.new_head = r_head;
        end
        o_res.goal = (o_res.new_row == i_cfg.goal_row) && (o_res.new_col == i_cfg.goal_col);
    end
    assign o_res_valid = fin;

    // Position after the step that finishes this cycle, before the new item applies.
    always_comb begin
        p_row  = r_row;
        p_col  = r_col;
        p_head = r_head;
        p_done = r_done;
        if (step_done) begin
            p_row  = o_res.new_row;
            p_col  = o_res.new_col;
            p_head = o_res.new_head;
            p_done = o_res.goal;
        end
    end

    always_comb begin
        n_row      = p_row;
        n_col      = p_col;
        n_head     = p_head;
        n_done     = p_done;
        n_active   = r_active;
        start_step = 1'b0;
        wr_en      = 1'b0;
        if (in_acc) begin
            unique case (i_kind)
                lhwf_pkg::KIND_WRITE: begin
                    wr_en = lhwf_pkg::in_store(i_cell_row, i_cell_col);
                end
                lhwf_pkg::KIND_RESTART: begin
                    n_row    = i_cfg.start_row;
                    n_col    = i_cfg.start_col;
                    n_head   = lhwf_pkg::DIR_E;
                    n_done   = 1'b0;
                    n_active = 1'b1;
                end
                lhwf_pkg::KIND_STEP: begin
                    start_step = r_active && !p_done;
                end
                default: begin
                end
            endcase
        end
    end

    assign acc_left_t = lhwf_pkg::step_target(n_row, n_col, n_head + 2'd3,
                                              i_cfg.rows_used, i_cfg.cols_used);

    always_comb begin
        n_state = r_state;
        if (rd_front) n_state = W_FRONT;
        if (step_done) n_state = W_IDLE;
        if (start_step) n_state = W_LEFT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= W_IDLE;
            r_row    <= 4'd0;
            r_col    <= 4'd0;
            r_head   <= lhwf_pkg::DIR_E;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_head   <= n_head;
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    // Wall memory: one write port, current-cell read and neighbor read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[lhwf_pkg::cell_addr(i_cell_row, i_cell_col)] <= i_wall_bits;
        end
        if (start_step) begin
            r_cur_w <= r_mem[lhwf_pkg::cell_addr(n_row, n_col)];
            r_tgt_w <= r_mem[lhwf_pkg::cell_addr(acc_left_t.row, acc_left_t.col)];
        end else if (rd_front) begin
            r_tgt_w <= r_mem[lhwf_pkg::cell_addr(front_t.row, front_t.col)];
        end
    end

    a_front_after_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == W_FRONT && $past(r_state) != W_FRONT) |-> $past(r_state) == W_LEFT)
        else $error("front check entered without a left check");

    a_idle_when_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_active || r_done) |-> r_state == W_IDLE)
        else $error("step in progress while inactive or finished");

    a_pos_follows_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_done && !(in_acc && i_kind == lhwf_pkg::KIND_RESTART)) |=>
        (r_row == $past(o_res.new_row) && r_col == $past(o_res.new_col)))
        else $error("position does not match the handed-off step");

endmodule

`default_nettype wire

### rtl/lhwf_emit.sv
// Record emitter: buffers step results in two slots and sends the two or three
// path records of each step, one per cycle while i_stall is low, on the output channel.
// Depends on lhwf_pkg.
`default_nettype none

module lhwf_emit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_res_valid,
    output logic                     o_res_stall,
    input  wire lhwf_pkg::t_step_res i_res,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [3:0]               o_path_row,
    output logic [3:0]               o_path_col,
    output logic [1:0]               o_heading,
    output logic                     o_reached_goal,
    output logic                     o_last
);

    lhwf_pkg::t_step_res r_cur, n_cur;
    lhwf_pkg::t_step_res r_nxt, n_nxt;
    logic                r_cur_full, n_cur_full;
    logic                r_nxt_full, n_nxt_full;
    logic [1:0]          r_idx, n_idx;

    logic push;
    logic pop;
    logic cur_free;

    assign o_res_stall = r_nxt_full;
    assign push        = i_res_valid && !r_nxt_full;

    always_comb begin
        o_path_row     = r_cur.new_row;
        o_path_col     = r_cur.new_col;
        o_heading      = r_cur.new_head;
        o_reached_goal = r_cur.goal;
        o_last         = (r_idx == 2'd2) || (r_idx == 2'd1 && !r_cur.left_turn);
        if (r_idx == 2'd0) begin
            o_path_row = r_cur.old_row;
            o_path_col = r_cur.old_col;
            o_heading  = r_cur.old_head;
        end else if (!o_last) begin
            // Turned left but not yet moved.
            o_path_row = r_cur.old_row;
            o_path_col = r_cur.old_col;
        end
    end
    assign o_valid = r_cur_full;

    assign pop      = r_cur_full && !i_stall;
    assign cur_free = !r_cur_full || (pop && o_last);

    always_comb begin
        n_cur      = r_cur;
        n_nxt      = r_nxt;
        n_cur_full = r_cur_full;
        n_nxt_full = r_nxt_full;
        n_idx      = r_idx;
        if (cur_free) begin
            n_idx = 2'd0;
            if (r_nxt_full) begin
                n_cur      = r_nxt;
                n_cur_full = 1'b1;
                n_nxt_full = 1'b0;
            end else if (push) begin
                n_cur      = i_res;
                n_cur_full = 1'b1;
            end else begin
                n_cur_full = 1'b0;
            end
        end else begin
            if (pop) n_idx = r_idx + 2'd1;
            if (push) begin
                n_nxt      = i_res;
                n_nxt_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_full <= 1'b0;
            r_nxt_full <= 1'b0;
            r_idx      <= 2'd0;
        end else begin
            r_cur_full <= n_cur_full;
            r_nxt_full <= n_nxt_full;
            r_idx      <= n_idx;
        end
        r_cur <= n_cur;
        r_nxt <= n_nxt;
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_full |-> (r_idx == 2'd0 || r_idx == 2'd1 || (r_idx == 2'd2 && r_cur.left_turn)))
        else $error("record index past the end of the step");

    a_more_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("step records dropped before the last one");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nxt_full |-> r_cur_full)
        else $error("pending slot full while current slot empty");

endmodule

`default_nettype wire

### rtl/left_hand_wall_follower.sv
// Left-hand wall follower, top level: configuration registers, walker core and
// record emitter. Depends on lhwf_pkg, lhwf_walker and lhwf_emit.
//
// Usage:
//   Input channel (i_valid / o_stall) carries items of three kinds: write one
//   cell's walls, restart at the start cell heading east, or step. Output
//   channel (o_valid / i_stall) carries path records; each step that runs gives
//   two or three records, the final one marked by o_last.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), to be
//   written only while the block is idle.
//   Wall writes and restarts are each taken at once while no step is in progress.
//   A step that moves left frees the input once the emitter can take it, any
//   other step only later, set by the rounds of wall memory reads (current and
//   left cell, then front cell). Records leave one per cycle while i_stall is low.
//   The first record of a step is registered in the emitter once the walker hands
//   it over. Steps while inactive or finished are taken and give nothing.
//   Reset: position (0,0) heading east, inactive, registers at their defaults;
//   the wall memory is not cleared. While i_stall is high, two resolved steps
//   wait in the emitter and a third in the walker, which then stalls the input.
`default_nettype none

module left_hand_wall_follower (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_kind,
    input  wire logic [3:0] i_cell_row,
    input  wire logic [3:0] i_cell_col,
    input  wire logic [3:0] i_wall_bits,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [3:0]      o_path_row,
    output logic [3:0]      o_path_col,
    output logic [1:0]      o_heading,
    output logic            o_reached_goal,
    output logic            o_last,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_idx,
    input  wire logic [4:0] i_cfg_data
);

    logic [4:0] r_maze_rows;
    logic [4:0] r_maze_cols;
    logic [3:0] r_start_row;
    logic [3:0] r_start_col;
    logic [3:0] r_goal_row;
    logic [3:0] r_goal_col;

    lhwf_pkg::t_cfg      cfg;
    lhwf_pkg::t_step_res res;
    logic                res_valid;
    logic                res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_rows <= 5'd16;
            r_maze_cols <= 5'd16;
            r_start_row <= 4'd0;
            r_start_col <= 4'd0;
            r_goal_row  <= 4'd15;
            r_goal_col  <= 4'd15;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lhwf_pkg::CFG_MAZE_ROWS: r_maze_rows <= i_cfg_data;
                lhwf_pkg::CFG_MAZE_COLS: r_maze_cols <= i_cfg_data;
                lhwf_pkg::CFG_START_ROW: r_start_row <= i_cfg_data[3:0];
                lhwf_pkg::CFG_START_COL: r_start_col <= i_cfg_data[3:0];
                lhwf_pkg::CFG_GOAL_ROW:  r_goal_row  <= i_cfg_data[3:0];
                lhwf_pkg::CFG_GOAL_COL:  r_goal_col  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp the maze size to the store.
    always_comb begin
        cfg.rows_used = (r_maze_rows > lhwf_pkg::ROW_LIM) ? lhwf_pkg::ROW_LIM : r_maze_rows;
        cfg.cols_used = (r_maze_cols > lhwf_pkg::COL_LIM) ? lhwf_pkg::COL_LIM : r_maze_cols;
        cfg.start_row = r_start_row;
        cfg.start_col = r_start_col;
        cfg.goal_row  = r_goal_row;
        cfg.goal_col  = r_goal_col;
    end

    lhwf_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_kind      (i_kind),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_wall_bits (i_wall_bits),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res)
    );

    lhwf_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res_valid    (res_valid),
        .o_res_stall    (res_stall),
        .i_res          (res),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_path_row     (o_path_row),
        .o_path_col     (o_path_col),
        .o_heading      (o_heading),
        .o_reached_goal (o_reached_goal),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

### tb/lhwf_path_check_pkg.sv
`timescale 1ns / 100ps
// Path record scoreboard for the left-hand wall follower testbench: a walker
// predictor fed with accepted items and a queue of the records it expects.
// Depends on lhwf_pkg for geometry, item kinds, headings and register indexes.

package lhwf_path_check_pkg;

    import lhwf_pkg::*;

    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [3:0] row;
        logic [3:0] col;
        logic [1:0] head;
        logic       goal;
        logic       last;
    } t_path_rec;

    class t_path_checker;
        logic [3:0] cell_walls [MAX_CELLS];
        logic [4:0] rows_cfg;
        logic [4:0] cols_cfg;
        logic [3:0] start_r;
        logic [3:0] start_c;
        logic [3:0] goal_r;
        logic [3:0] goal_c;
        logic [3:0] pos_r;
        logic [3:0] pos_c;
        logic [1:0] head;
        bit         walking;
        bit         finished;
        t_path_rec  pending_path [$];
        int         errors;

        function new();
            foreach (cell_walls[i]) cell_walls[i] = 4'd0;
            rows_cfg = 5'd16;
            cols_cfg = 5'd16;
            start_r  = 4'd0;
            start_c  = 4'd0;
            goal_r   = 4'd15;
            goal_c   = 4'd15;
            pos_r    = 4'd0;
            pos_c    = 4'd0;
            head     = DIR_E;
            walking  = 1'b0;
            finished = 1'b0;
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [4:0] data);
            case (idx)
                CFG_MAZE_ROWS: rows_cfg = data;
                CFG_MAZE_COLS: cols_cfg = data;
                CFG_START_ROW: start_r  = data[3:0];
                CFG_START_COL: start_c  = data[3:0];
                CFG_GOAL_ROW:  goal_r   = data[3:0];
                CFG_GOAL_COL:  goal_c   = data[3:0];
                default: ;
            endcase
        endfunction

        function logic [3:0] walls_at(int r, int c);
            if (r >= MAX_ROWS || c >= MAX_COLS) return 4'hF;
            return cell_walls[r * MAX_COLS + c];
        endfunction

        // Neighbor in direction dir, reachable only if inside the maze in use
        // and open on both sides of the shared wall.
        function bit try_move(logic [1:0] dir, output logic [3:0] nr,
                              output logic [3:0] nc);
            int         r;
            int         c;
            int         rlim;
            int         clim;
            logic [3:0] here;
            logic [3:0] there;
            logic [1:0] back;
            r    = pos_r;
            c    = pos_c;
            rlim = (rows_cfg > ROW_LIM) ? int'(ROW_LIM) : int'(rows_cfg);
            clim = (cols_cfg > COL_LIM) ? int'(COL_LIM) : int'(cols_cfg);
            case (dir)
                DIR_N: r = r - 1;
                DIR_E: c = c + 1;
                DIR_S: r = r + 1;
                DIR_W: c = c - 1;
            endcase
            nr = r[3:0];
            nc = c[3:0];
            if (r < 0 || c < 0 || r >= rlim || c >= clim) return 1'b0;
            here  = walls_at(pos_r, pos_c);
            there = walls_at(r, c);
            back  = dir + 2'd2;
            return !here[dir] && !there[back];
        endfunction

        // Apply one accepted item; return the number of records it causes.
        function int note_item(logic [1:0] kind, logic [3:0] row, logic [3:0] col,
                               logic [3:0] walls);
            t_path_rec  step_recs [3];
            int         n_rec;
            t_path_rec  rec;
            logic [3:0] nr;
            logic [3:0] nc;
            logic [1:0] left_dir;
            n_rec = 0;
            case (kind)
                KIND_WRITE: begin
                    if (row < MAX_ROWS && col < MAX_COLS)
                        cell_walls[row * MAX_COLS + col] = walls;
                end
                KIND_RESTART: begin
                    pos_r    = start_r;
                    pos_c    = start_c;
                    head     = DIR_E;
                    finished = 1'b0;
                    walking  = 1'b1;
                end
                KIND_STEP: begin
                    if (walking && !finished) begin
                        step_recs[n_rec] = {pos_r, pos_c, head, 2'b00};
                        n_rec++;
                        left_dir = head - 2'd1;
                        if (try_move(left_dir, nr, nc)) begin
                            head = left_dir;
                            step_recs[n_rec] = {pos_r, pos_c, head, 2'b00};
                            n_rec++;
                            pos_r = nr;
                            pos_c = nc;
                        end else if (try_move(head, nr, nc)) begin
                            pos_r = nr;
                            pos_c = nc;
                        end else begin
                            head = head + 2'd1;
                        end
                        step_recs[n_rec] = {pos_r, pos_c, head, 2'b00};
                        n_rec++;
                        if (pos_r == goal_r && pos_c == goal_c) finished = 1'b1;
                        for (int i = 0; i < n_rec; i++) begin
                            rec      = step_recs[i];
                            rec.goal = finished;
                            rec.last = (i == n_rec - 1);
                            pending_path.insert(pending_path.size(), rec);
                        end
                    end
                end
                default: ;
            endcase
            return n_rec;
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_record(t_path_rec got);
            t_path_rec want;
            if (pending_path.size() == 0) begin
                report($sformatf("record (%0d,%0d) head %0d with none expected",
                                 got.row, got.col, got.head));
                return;
            end
            want = pending_path.pop_front();
            if (got.row !== want.row)
                report($sformatf("path_row %0d, want %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("path_col %0d, want %0d", got.col, want.col));
            if (got.head !== want.head)
                report($sformatf("heading %0d, want %0d", got.head, want.head));
            if (got.goal !== want.goal)
                report($sformatf("reached_goal %b, want %b", got.goal, want.goal));
            if (got.last !== want.last)
                report($sformatf("last %b, want %b", got.last, want.last));
        endtask
    endclass

endpackage

### tb/left_hand_wall_follower_tb.sv
`timescale 1ns / 100ps
// Testbench for left_hand_wall_follower: maze fill, directed walks, then random
// phases over several maze settings and idle patterns. Depends on lhwf_pkg and
// lhwf_path_check_pkg.

module left_hand_wall_follower_tb;

    import lhwf_pkg::*;
    import lhwf_path_check_pkg::*;

    localparam logic [1:0] KIND_SPARE    = 2'd3;
    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         PHASES        = 8;
    localparam int         PHASE_ITEMS   = 18;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [1:0] i_kind      = KIND_WRITE;
    logic [3:0] i_cell_row  = 4'd0;
    logic [3:0] i_cell_col  = 4'd0;
    logic [3:0] i_wall_bits = 4'd0;
    logic       i_stall     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [2:0] i_cfg_idx   = CFG_MAZE_ROWS;
    logic [4:0] i_cfg_data  = 5'd0;
    logic       o_stall;
    logic       o_valid;
    logic [3:0] o_path_row;
    logic [3:0] o_path_col;
    logic [1:0] o_heading;
    logic       o_reached_goal;
    logic       o_last;

    t_path_checker board = new();
    int            send_idle_pct = 0;
    int            stall_pct     = 0;
    bit            hold_req      = 1'b0;
    logic          hold_off      = 1'b0;

    left_hand_wall_follower u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_wall_bits    (i_wall_bits),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_path_row     (o_path_row),
        .o_path_col     (o_path_col),
        .o_heading      (o_heading),
        .o_reached_goal (o_reached_goal),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Hold the output side off for a long stretch so the block backs up.
    initial begin : long_hold
        wait (hold_req);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_record({o_path_row, o_path_col, o_heading, o_reached_goal, o_last});
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    function automatic logic [3:0] sparse_walls();
        if ($urandom_range(3) == 0) return 4'($urandom_range(15));
        return 4'($urandom_range(15) & $urandom_range(15) & $urandom_range(15));
    endfunction

    task automatic send_item(input logic [1:0] kind, input logic [3:0] row,
                             input logic [3:0] col, input logic [3:0] walls,
                             output int produced);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_kind      <= kind;
        i_cell_row  <= row;
        i_cell_col  <= col;
        i_wall_bits <= walls;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        produced = board.note_item(kind, row, col, walls);
    endtask

    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_path.size() != 0) @(posedge i_clk);
    endtask

    // Steps that give nothing may still be in flight after the last record.
    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_word(input logic [2:0] idx, input logic [4:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic set_maze(input logic [4:0] rows, input logic [4:0] cols,
                            input logic [3:0] sr, input logic [3:0] sc,
                            input logic [3:0] gr, input logic [3:0] gc);
        cfg_word(CFG_MAZE_ROWS, rows);
        cfg_word(CFG_MAZE_COLS, cols);
        cfg_word(CFG_START_ROW, {1'b0, sr});
        cfg_word(CFG_START_COL, {1'b0, sc});
        cfg_word(CFG_GOAL_ROW, {1'b0, gr});
        cfg_word(CFG_GOAL_COL, {1'b0, gc});
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_walks();
        int produced;
        // inactive after reset: step and spare kind give nothing
        send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
        send_item(KIND_SPARE, 4'hF, 4'hF, 4'hF, produced);
        wait_idle();
        // single cell that is also the goal: turn in place finishes the walk
        set_maze(5'd1, 5'd1, 4'd0, 4'd0, 4'd0, 4'd0);
        send_item(KIND_RESTART, 4'd0, 4'd0, 4'd0, produced);
        send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
        send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
        wait_idle();
        set_maze(5'd2, 5'd2, 4'd0, 4'd0, 4'd1, 4'd1);
        send_item(KIND_WRITE, 4'd0, 4'd0, 4'd0, produced);
        send_item(KIND_WRITE, 4'd0, 4'd1, 4'd0, produced);
        send_item(KIND_WRITE, 4'd1, 4'd0, 4'd0, produced);
        send_item(KIND_WRITE, 4'd1, 4'd1, 4'd0, produced);
        send_item(KIND_RESTART, 4'd0, 4'd0, 4'd0, produced);
        repeat (3) send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
        // wall only on the far side of the shared edge, then a left move
        send_item(KIND_WRITE, 4'd0, 4'd1, 4'b1000, produced);
        send_item(KIND_RESTART, 4'd0, 4'd0, 4'd0, produced);
        repeat (3) send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
        // boxed in: only a right turn is left
        send_item(KIND_WRITE, 4'd0, 4'd0, 4'hF, produced);
        send_item(KIND_RESTART, 4'd0, 4'd0, 4'd0, produced);
        send_item(KIND_STEP, 4'd0, 4'd0, 4'd0, produced);
    endtask

    task automatic run_phase(input int phase);
        logic [4:0] rows;
        logic [4:0] cols;
        logic [3:0] sr;
        logic [3:0] sc;
        logic [3:0] gr;
        logic [3:0] gc;
        logic [3:0] r;
        logic [3:0] c;
        int         rlim;
        int         clim;
        int         counted;
        int         produced;
        int         pick;
        bit         drained;
        sr = 4'($urandom);
        sc = 4'($urandom);
        gr = 4'($urandom);
        gc = 4'($urandom);
        case (phase)
            0: begin
                rows = 5'd16; cols = 5'd16;
                sr = 4'd0; sc = 4'd0; gr = 4'd15; gc = 4'd15;
            end
            1: begin
                rows = 5'd31; cols = 5'd31;
            end
            2: begin
                rows = 5'd1; cols = 5'd1;
                sr = 4'd0; sc = 4'd0; gr = 4'd0; gc = 4'd0;
            end
            3: begin
                rows = 5'd0; cols = 5'd16;
            end
            4: begin
                rows = 5'd2; cols = 5'd3;
                sr = 4'($urandom_range(1)); sc = 4'($urandom_range(2));
                gr = 4'($urandom_range(1)); gc = 4'($urandom_range(2));
            end
            5: begin
                rows = 5'($urandom_range(5, 1)); cols = 5'($urandom_range(5, 1));
                sr = 4'($urandom_range(rows - 1)); sc = 4'($urandom_range(cols - 1));
                gr = 4'($urandom_range(rows - 1)); gc = 4'($urandom_range(cols - 1));
            end
            6: begin
                rows = 5'd16; cols = 5'd1;
                sr = 4'd15; sc = 4'd0; gr = 4'd0; gc = 4'd0;
            end
            default: begin
                // start outside the maze in use: the walker can only turn
                rows = 5'd5; cols = 5'd16;
                sr = 4'd12; sc = 4'd3;
            end
        endcase
        rlim = (rows > 5'd16) ? 16 : int'(rows);
        clim = (cols > 5'd16) ? 16 : int'(cols);
        wait_idle();
        set_maze(rows, cols, sr, sc, gr, gc);
        case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
        endcase
        if (phase == 0) hold_req = 1'b1;
        send_item(KIND_RESTART, 4'($urandom), 4'($urandom), 4'($urandom), produced);
        counted = 1;
        drained = 1'b0;
        while (counted < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (board.finished && $urandom_range(1) == 0) pick = 0;
            if (pick < 8) begin
                send_item(KIND_RESTART, 4'($urandom), 4'($urandom), 4'($urandom),
                          produced);
                counted++;
            end else if (pick < 14) begin
                if (rlim == 0 || clim == 0 || $urandom_range(3) == 0) begin
                    r = 4'($urandom);
                    c = 4'($urandom);
                end else begin
                    r = 4'($urandom_range(rlim - 1));
                    c = 4'($urandom_range(clim - 1));
                end
                send_item(KIND_WRITE, r, c, sparse_walls(), produced);
                counted++;
            end else if (pick < 18) begin
                send_item(KIND_SPARE, 4'($urandom), 4'($urandom), 4'($urandom), produced);
            end else begin
                send_item(KIND_STEP, 4'($urandom), 4'($urandom), 4'($urandom), produced);
                if (produced > 0) counted++;
            end
            // pause the input once per phase until the output side catches up
            if (!drained && counted >= PHASE_ITEMS / 2) begin
                wait_results();
                drained = 1'b1;
            end
        end
    endtask

    initial begin : stimulus
        int produced;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // write every location of the store so no step reads an unwritten one
        for (int loc = 0; loc < MAX_CELLS; loc++)
            send_item(KIND_WRITE, 4'(loc / MAX_COLS), 4'(loc % MAX_COLS),
                      sparse_walls(), produced);
        directed_walks();
        for (int p = 0; p < PHASES; p++) run_phase(p);
        wait_idle();
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
